@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 4096;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] HEADER_RST       = 8'hA5;
   localparam logic [7:0] USER_ID_RST      = 8'h01;
   localparam logic [7:0] CONFIRM_TYPE_RST = 8'hFF;
   localparam logic [7:0] HANDSHAKE_TYPE   = 8'h01;
   localparam logic [7:0] CONFIRM_LEN_LO   = 8'h04;
   localparam logic [7:0] CONFIRM_PAY0     = 8'hA5;
   localparam logic [3:0] CONFIRM_BYTES    = 4'd12;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_CONFIRM = 2'd2;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

   typedef enum logic [1:0] {
      CSR_HEADER       = 2'd0,
      CSR_USER_ID      = 2'd1,
      CSR_CONFIRM_TYPE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_UID     = 4'd1,
      PH_TYPE    = 4'd2,
      PH_LEN_LO  = 4'd3,
      PH_LEN_HI  = 4'd4,
      PH_SID_LO  = 4'd5,
      PH_SID_HI  = 4'd6,
      PH_DATA    = 4'd7,
      PH_CHECK   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      OP_DATA        = 2'd0,
      OP_END         = 2'd1,
      OP_END_CONFIRM = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] header;
      logic [7:0] user_id;
      logic [7:0] confirm_type;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [7:0]  ftype;
      logic [15:0] sid;
      logic [1:0]  status;
      logic        hs_done;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  ftype;
      logic [15:0] sid;
      logic [1:0]  status;
      logic        hs_done;
      logic        last;
   } res_type;

   // byte i (0..11) of the handshake confirm frame
   function automatic logic [7:0] confirm_byte(input logic [3:0] idx,
                                               input cfg_type cfg,
                                               input logic [15:0] sid);
      logic [7:0] sum;
      logic [7:0] b;
      sum = cfg.header + cfg.user_id + cfg.confirm_type + CONFIRM_LEN_LO
            + sid[7:0] + sid[15:8] + CONFIRM_PAY0;
      case (idx)
         4'd0:    b = cfg.header;
         4'd1:    b = cfg.user_id;
         4'd2:    b = cfg.confirm_type;
         4'd3:    b = CONFIRM_LEN_LO;
         4'd5:    b = sid[7:0];
         4'd6:    b = sid[15:8];
         4'd7:    b = CONFIRM_PAY0;
         4'd11:   b = 8'(8'd0 - sum);
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/sfr_if.sv @@
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  data_byte;
   logic [7:0]  frame_type;
   logic [15:0] sequence_id;
   logic [1:0]  frame_status;
   logic        handshake_done;
   logic        last_of_run;
   modport source (output valid, output result_kind, output data_byte, output frame_type,
                   output sequence_id, output frame_status, output handshake_done,
                   output last_of_run, input ready);
   modport sink (input valid, input result_kind, input data_byte, input frame_type,
                 input sequence_id, input frame_status, input handshake_done,
                 input last_of_run, output ready);
endinterface

@@ rtl/sfr_parser.sv @@
module sfr_parser #(
   parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output logic             push,
   output sfr_pkg::cmd_type cmd
);
   import sfr_pkg::*;

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] sid_ff, sid_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic        hs_ff, hs_in;

   logic [15:0] len_full;
   logic [15:0] cnt_next;
   logic [7:0]  sum_add;
   logic        too_big;
   logic        good;
   logic        hs_frame;

   assign len_full = {rx_byte, len_ff[7:0]};
   assign too_big  = len_full > MaxLen;
   assign cnt_next = cnt_ff + 16'd1;
   assign sum_add  = sum_ff + rx_byte;
   assign good     = (sum_add == 8'd0);
   assign hs_frame = good && (type_ff == HANDSHAKE_TYPE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_UID: begin
               if (rx_byte == cfg.user_id) phase_in = PH_TYPE;
               else if (rx_byte == cfg.header) phase_in = PH_UID;
               else phase_in = PH_HUNT;
            end
            PH_TYPE:   phase_in = PH_LEN_LO;
            PH_LEN_LO: phase_in = PH_LEN_HI;
            PH_LEN_HI: phase_in = too_big ? PH_HUNT : PH_SID_LO;
            PH_SID_LO: phase_in = PH_SID_HI;
            PH_SID_HI: phase_in = (len_ff == 16'd0) ? PH_CHECK : PH_DATA;
            PH_DATA:   phase_in = (cnt_next >= len_ff) ? PH_CHECK : PH_DATA;
            PH_CHECK:  phase_in = PH_HUNT;
            default:   phase_in = (rx_byte == cfg.header) ? PH_UID : PH_HUNT;
         endcase
      end
   end

   // field capture and command generation
   always_comb begin
      type_in = type_ff;
      len_in  = len_ff;
      sid_in  = sid_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      hs_in   = hs_ff;
      push    = 1'b0;
      cmd     = '{op: OP_DATA, data: rx_byte, ftype: type_ff, sid: sid_ff,
                  status: STATUS_GOOD, hs_done: hs_ff};
      if (accept) begin
         unique case (phase_ff)
            PH_UID: begin
               if (rx_byte == cfg.user_id) begin
                  sum_in = sum_add;
               end else if (rx_byte == cfg.header) begin
                  sum_in  = rx_byte;
                  type_in = 8'd0;
                  len_in  = 16'd0;
                  sid_in  = 16'd0;
                  cnt_in  = 16'd0;
               end
            end
            PH_TYPE: begin
               type_in = rx_byte;
               sum_in  = sum_add;
            end
            PH_LEN_LO: begin
               len_in = {8'd0, rx_byte};
               sum_in = sum_add;
            end
            PH_LEN_HI: begin
               len_in = len_full;
               sum_in = sum_add;
               if (too_big) begin
                  push       = 1'b1;
                  cmd.op     = OP_END;
                  cmd.data   = 8'd0;
                  cmd.ftype  = 8'd0;
                  cmd.sid    = 16'd0;
                  cmd.status = STATUS_TOO_BIG;
               end
            end
            PH_SID_LO: begin
               sid_in = {8'd0, rx_byte};
               sum_in = sum_add;
            end
            PH_SID_HI: begin
               sid_in = {rx_byte, sid_ff[7:0]};
               sum_in = sum_add;
               cnt_in = 16'd0;
            end
            PH_DATA: begin
               sum_in = sum_add;
               cnt_in = cnt_next;
               push   = 1'b1;
            end
            PH_CHECK: begin
               hs_in       = hs_ff | hs_frame;
               push        = 1'b1;
               cmd.op      = hs_frame ? OP_END_CONFIRM : OP_END;
               cmd.data    = 8'd0;
               cmd.status  = good ? STATUS_GOOD : STATUS_BAD_SUM;
               cmd.hs_done = hs_ff | hs_frame;
            end
            default: begin
               if (rx_byte == cfg.header) begin
                  sum_in  = rx_byte;
                  type_in = 8'd0;
                  len_in  = 16'd0;
                  sid_in  = 16'd0;
                  cnt_in  = 16'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         type_ff  <= 8'd0;
         len_ff   <= 16'd0;
         sid_ff   <= 16'd0;
         cnt_ff   <= 16'd0;
         sum_ff   <= 8'd0;
         hs_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         sid_ff   <= sid_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         hs_ff    <= hs_in;
      end
   end

endmodule

@@ rtl/sfr_cmd_fifo.sv @@
module sfr_cmd_fifo #(
   parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::cmd_type wr_data,
   input  logic             pop,
   output sfr_pkg::cmd_type rd_data,
   output logic             empty,
   output logic             full
);
   import sfr_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

   cmd_type       mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FullCnt);
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
      if (pop) rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/sfr_emitter.sv @@
module sfr_emitter (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  sfr_pkg::cmd_type cmd,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output sfr_pkg::res_type out_res
);
   import sfr_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   res_type    res_ff, res_in;
   logic       load;

   // output register refills whenever a command is waiting and it is empty or being drained
   assign load      = cmd_valid && (!valid_ff || out_ready);
   assign pop       = load && res_in.last;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      res_in = '{kind: KIND_DATA, data: cmd.data, ftype: cmd.ftype, sid: cmd.sid,
                 status: STATUS_GOOD, hs_done: cmd.hs_done, last: 1'b1};
      unique case (cmd.op)
         OP_DATA: res_in.kind = KIND_DATA;
         OP_END: begin
            res_in.kind   = KIND_END;
            res_in.data   = 8'd0;
            res_in.status = cmd.status;
         end
         OP_END_CONFIRM: begin
            // frame end first, then the twelve confirm bytes
            if (idx_ff == 4'd0) begin
               res_in.kind   = KIND_END;
               res_in.data   = 8'd0;
               res_in.status = cmd.status;
               res_in.last   = 1'b0;
            end else begin
               res_in.kind = KIND_CONFIRM;
               res_in.data = confirm_byte(idx_ff - 4'd1, cfg, cmd.sid);
               res_in.last = (idx_ff == CONFIRM_BYTES);
            end
         end
         default: res_in.kind = KIND_DATA;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = res_in.last ? 4'd0 : idx_ff + 4'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/serial_frame_receiver_with_handshake_ack_top.sv @@
// An accepted byte passes the command queue and the emitter's output register
// before its first result beat. Throughput: one byte per cycle while the queue
// has room; the result side sends one beat per cycle while ready is high, so a
// handshake frame end with twelve confirm bytes is a burst the queue absorbs.
// Reset (synchronous, active high) restores the registers to their defaults,
// returns the parser to header hunting, clears the handshake flag and queue.
module serial_frame_receiver_with_handshake_ack_top #(
   parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
   parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_if,
   sfr_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cmd_type push_cmd;
   cmd_type head_cmd;
   res_type res;
   logic    push;
   logic    pop;
   logic    q_empty;
   logic    q_full;
   logic    accept;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{header: HEADER_RST, user_id: USER_ID_RST,
                     confirm_type: CONFIRM_TYPE_RST};
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER:       cfg_ff.header       <= csr_wdata;
            CSR_USER_ID:      cfg_ff.user_id      <= csr_wdata;
            CSR_CONFIRM_TYPE: cfg_ff.confirm_type <= csr_wdata;
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   sfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .rx_byte (req_if.rx_byte),
      .push    (push),
      .cmd     (push_cmd)
   );

   sfr_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_cmd),
      .pop     (pop),
      .rd_data (head_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   sfr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!q_empty),
      .cmd       (head_cmd),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_res   (res)
   );

   assign rsp_if.result_kind    = res.kind;
   assign rsp_if.data_byte      = res.data;
   assign rsp_if.frame_type     = res.ftype;
   assign rsp_if.sequence_id    = res.sid;
   assign rsp_if.frame_status   = res.status;
   assign rsp_if.handshake_done = res.hs_done;
   assign rsp_if.last_of_run    = res.last;

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.result_kind != KIND_END |-> rsp_if.frame_status == STATUS_GOOD)
      else $error("frame status set on a non frame-end beat");

   a_len_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_status == STATUS_TOO_BIG
      |-> rsp_if.frame_type == 8'd0 && rsp_if.sequence_id == 16'd0 && rsp_if.last_of_run)
      else $error("length error beat carries frame fields");

   a_handshake_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.handshake_done
      |=> !rsp_if.valid || rsp_if.handshake_done)
      else $error("handshake flag dropped");

   a_confirm_follows_end: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.result_kind == KIND_END && !rsp_if.last_of_run
      |=> rsp_if.valid && rsp_if.result_kind == KIND_CONFIRM)
      else $error("confirm frame does not follow its frame end");

endmodule

@@ tb/tb_serial_frame_receiver_with_handshake_ack_top.sv @@
module tb_serial_frame_receiver_with_handshake_ack_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [7:0] rx;
      logic       canned;   // expected beat typed in below, not predicted
      logic       has_res;
      res_type    res;
   } byte_job_type;

   localparam res_type NO_BEAT = '0;
   localparam res_type TOO_BIG_BEAT = '{KIND_END, 8'h00, 8'h00, 16'h0000, STATUS_TOO_BIG,
                                        1'b0, 1'b1};

   // reset defaults: noise, oversize length, zero-length handshake,
   // header inside uid slot, payload extremes with a bad checksum
   localparam byte_job_type DIRECTED [25] = '{
      '{8'h00, 1'b1, 1'b0, NO_BEAT},
      '{8'hA5, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h07, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h10, 1'b1, 1'b1, TOO_BIG_BEAT},
      '{8'hA5, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h34, 1'b0, 1'b0, NO_BEAT},
      '{8'h12, 1'b0, 1'b0, NO_BEAT},
      '{8'h13, 1'b0, 1'b0, NO_BEAT},
      '{8'hA5, 1'b0, 1'b0, NO_BEAT},
      '{8'hA5, 1'b0, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h02, 1'b0, 1'b0, NO_BEAT},
      '{8'h02, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT}
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   sfr_req_if req_bus();
   sfr_rsp_if rsp_bus();

   serial_frame_receiver_with_handshake_ack_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [7:0] cfg_header = HEADER_RST;
   logic [7:0] cfg_uid    = USER_ID_RST;
   logic [7:0] cfg_ctype  = CONFIRM_TYPE_RST;

   // deframer state
   phase_type   parse_phase = PH_HUNT;
   logic [7:0]  cur_type    = 8'h00;
   logic [15:0] pay_len     = 16'h0000;
   logic [15:0] frame_sid   = 16'h0000;
   logic [15:0] pay_cnt     = 16'h0000;
   logic [7:0]  run_sum     = 8'h00;
   logic        hs_seen     = 1'b0;

   res_type      step_out[$];
   res_type      pending_results[$];
   byte_job_type rx_backlog[$];
   byte_job_type in_flight;

   int unsigned cycle_count    = 0;
   int unsigned mismatch_total = 0;
   int unsigned queued_bytes   = 0;
   int unsigned beats_checked  = 0;
   int unsigned confirm_count  = 0;
   int unsigned too_big_count  = 0;
   bit          no_stall       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               pending_results.size());
      $display("serial_frame_receiver_with_handshake_ack_top verification failed");
      $finish;
   end

   function automatic void add_beat(logic [1:0] kind, logic [7:0] data, logic [7:0] ft,
                                    logic [15:0] sid, logic [1:0] st);
      res_type r;
      r.kind    = kind;
      r.data    = data;
      r.ftype   = ft;
      r.sid     = sid;
      r.status  = st;
      r.hs_done = hs_seen;
      r.last    = 1'b0;
      step_out  = {step_out, r};
   endfunction

   function automatic void open_frame(logic [7:0] b);
      run_sum     = b;
      cur_type    = 8'h00;
      pay_len     = 16'h0000;
      frame_sid   = 16'h0000;
      pay_cnt     = 16'h0000;
      parse_phase = PH_UID;
   endfunction

   // advance the deframer by one rx byte; beats it causes land in step_out
   function automatic void deframe_byte(logic [7:0] b);
      logic [7:0] frame [12];
      logic [7:0] csum;
      bit         good;
      int         i;
      step_out.delete();
      case (parse_phase)
         PH_UID: begin
            if (b == cfg_uid) begin
               run_sum     = run_sum + b;
               parse_phase = PH_TYPE;
            end else if (b == cfg_header) begin
               open_frame(b);
            end else begin
               parse_phase = PH_HUNT;
            end
         end
         PH_TYPE: begin
            cur_type    = b;
            run_sum     = run_sum + b;
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            pay_len     = {8'h00, b};
            run_sum     = run_sum + b;
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            pay_len[15:8] = b;
            run_sum       = run_sum + b;
            if (pay_len > MAX_PAYLOAD_DEF) begin
               add_beat(KIND_END, 8'h00, 8'h00, 16'h0000, STATUS_TOO_BIG);
               too_big_count++;
               parse_phase = PH_HUNT;
            end else begin
               parse_phase = PH_SID_LO;
            end
         end
         PH_SID_LO: begin
            frame_sid   = {8'h00, b};
            run_sum     = run_sum + b;
            parse_phase = PH_SID_HI;
         end
         PH_SID_HI: begin
            frame_sid[15:8] = b;
            run_sum         = run_sum + b;
            pay_cnt         = 16'h0000;
            parse_phase     = (pay_len == 16'h0000) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            run_sum = run_sum + b;
            add_beat(KIND_DATA, b, cur_type, frame_sid, STATUS_GOOD);
            pay_cnt = pay_cnt + 16'd1;
            if (pay_cnt >= pay_len) parse_phase = PH_CHECK;
         end
         PH_CHECK: begin
            good = (8'(run_sum + b) == 8'h00);
            if (good && cur_type == HANDSHAKE_TYPE) hs_seen = 1'b1;
            add_beat(KIND_END, 8'h00, cur_type, frame_sid,
                     good ? STATUS_GOOD : STATUS_BAD_SUM);
            if (good && cur_type == HANDSHAKE_TYPE) begin
               frame = '{cfg_header, cfg_uid, cfg_ctype, CONFIRM_LEN_LO, 8'h00,
                         frame_sid[7:0], frame_sid[15:8], CONFIRM_PAY0,
                         8'h00, 8'h00, 8'h00, 8'h00};
               csum = 8'h00;
               for (i = 0; i < 11; i++) csum = csum + frame[i];
               frame[11] = 8'h00 - csum;
               for (i = 0; i < 12; i++)
                  add_beat(KIND_CONFIRM, frame[i], cur_type, frame_sid, STATUS_GOOD);
               confirm_count++;
            end
            parse_phase = PH_HUNT;
         end
         default: begin
            if (b == cfg_header) open_frame(b);
            else parse_phase = PH_HUNT;
         end
      endcase
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // rx side: drive beats, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            deframe_byte(req_bus.rx_byte);
            if (in_flight.canned) begin
               if (in_flight.has_res) pending_results = {pending_results, in_flight.res};
            end else begin
               pending_results = {pending_results, step_out};
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (rx_backlog.size() != 0 && (no_stall || $urandom_range(99) >= 10)) begin
               in_flight = rx_backlog.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= in_flight.rx;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) rsp_bus.ready <= no_stall || ($urandom_range(99) >= 10);

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got kind %0d data 0x%0h",
                     $time, rsp_bus.result_kind, rsp_bus.data_byte);
            mismatch_total++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.kind, rsp_bus.result_kind);
            check_field("data_byte", want.data, rsp_bus.data_byte);
            check_field("frame_type", want.ftype, rsp_bus.frame_type);
            check_field("sequence_id", want.sid, rsp_bus.sequence_id);
            check_field("frame_status", want.status, rsp_bus.frame_status);
            check_field("handshake_done", want.hs_done, rsp_bus.handshake_done);
            check_field("last_of_run", want.last, rsp_bus.last_of_run);
         end
         beats_checked++;
      end
   end

   task automatic queue_raw(logic [7:0] b);
      byte_job_type j;
      j          = '0;
      j.rx       = b;
      rx_backlog = {rx_backlog, j};
      queued_bytes++;
   endtask

   // whole frame from the current register values; oversize stops after length
   task automatic queue_frame(logic [7:0] ftype, int unsigned len, logic [15:0] sid,
                              bit bad_sum);
      logic [7:0]  head [7];
      logic [7:0]  sum;
      logic [7:0]  b;
      logic [15:0] len16;
      int unsigned i;
      len16 = 16'(len);
      head  = '{cfg_header, cfg_uid, ftype, len16[7:0], len16[15:8], sid[7:0], sid[15:8]};
      sum   = 8'h00;
      for (i = 0; i < 7; i++) begin
         if (i == 5 && len > MAX_PAYLOAD_DEF) return;
         queue_raw(head[i]);
         sum = sum + head[i];
      end
      for (i = 0; i < len; i++) begin
         b = 8'($urandom);
         queue_raw(b);
         sum = sum + b;
      end
      b = 8'h00 - sum;
      if (bad_sum) b = b + 8'($urandom_range(1, 255));
      queue_raw(b);
   endtask

   task automatic random_traffic(int unsigned goal);
      int unsigned stop_at;
      int unsigned pick;
      logic [7:0]  b;
      logic [15:0] sid;
      stop_at = queued_bytes + goal;
      while (queued_bytes < stop_at) begin
         pick = $urandom_range(99);
         sid  = 16'($urandom);
         if (pick < 40) begin
            queue_frame(($urandom_range(2) == 0) ? HANDSHAKE_TYPE : 8'($urandom),
                        ($urandom_range(99) < 85) ? $urandom_range(0, 6)
                                                  : $urandom_range(7, 40), sid, 1'b0);
         end else if (pick < 55) begin
            queue_frame(HANDSHAKE_TYPE, $urandom_range(0, 3), sid, 1'b0);
         end else if (pick < 65) begin
            queue_frame(($urandom_range(1) == 0) ? HANDSHAKE_TYPE : 8'($urandom),
                        $urandom_range(0, 6), sid, 1'b1);
         end else if (pick < 73) begin
            queue_frame(8'($urandom), $urandom_range(MAX_PAYLOAD_DEF + 1, 65535), sid, 1'b0);
         end else if (pick < 81) begin
            // header followed by a foreign user id
            queue_raw(cfg_header);
            do b = 8'($urandom); while (b == cfg_uid);
            queue_raw(b);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) queue_raw(8'($urandom));
         end else begin
            queue_raw(cfg_header);
            queue_frame(8'($urandom), $urandom_range(0, 4), sid, 1'b0);
         end
      end
   endtask

   // all beats accepted and answered, then let trailing work finish
   task automatic settle();
      while (rx_backlog.size() != 0 || req_bus.valid) @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HEADER:       cfg_header = val;
         CSR_USER_ID:      cfg_uid    = val;
         CSR_CONFIRM_TYPE: cfg_ctype  = val;
         default:          ;
      endcase
   endtask

   task automatic load_regs(logic [7:0] header, logic [7:0] uid, logic [7:0] ctype);
      set_reg(CSR_HEADER, header);
      set_reg(CSR_USER_ID, uid);
      set_reg(CSR_CONFIRM_TYPE, ctype);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_HEADER;
      csr_wdata       = 8'h00;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         rx_backlog = {rx_backlog, DIRECTED[i]};
         queued_bytes++;
      end
      settle();

      // mixed traffic on reset defaults
      random_traffic(75);
      settle();

      load_regs(8'h00, 8'hFF, 8'h00);
      no_stall = 1'b1;
      random_traffic(75);
      settle();
      no_stall = 1'b0;

      load_regs(8'hFF, 8'h00, 8'h7E);
      random_traffic(75);
      settle();

      load_regs(8'($urandom), 8'($urandom), 8'($urandom));
      random_traffic(75);
      settle();

      $display("sent %0d rx bytes under 4 register settings, %0d result beats checked",
               queued_bytes, beats_checked);
      $display("frames confirmed as handshakes: %0d, oversize lengths rejected: %0d",
               confirm_count, too_big_count);
      if (mismatch_total == 0) begin
         $display("serial_frame_receiver_with_handshake_ack_top verification clean");
      end else begin
         $display("serial_frame_receiver_with_handshake_ack_top verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_parser.sv
rtl/sfr_cmd_fifo.sv
rtl/sfr_emitter.sv
rtl/serial_frame_receiver_with_handshake_ack_top.sv
tb/tb_serial_frame_receiver_with_handshake_ack_top.sv
